@@ rtl/tsrr_pkg.sv @@
// Shared constants and codes for the thread-slot round-robin scheduler.
package tsrr_pkg;
    localparam int SLOT_COUNT_DEF = 256;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_YIELD  = 2'd2;
    localparam logic [1:0] MODE_JOIN   = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_READY = 2'd2;
    localparam logic [1:0] STS_NONE      = 2'd3;

    localparam logic [1:0] SL_FREE = 2'd0;
    localparam logic [1:0] SL_RUN  = 2'd1;
    localparam logic [1:0] SL_FIN  = 2'd2;
    localparam logic [1:0] SL_WJ   = 2'd3;
endpackage

@@ rtl/tsrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tsrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/thread_slot_round_robin_scheduler.sv @@
// Thread-slot round-robin scheduler: slot table in RAMs, sequenced request engine.
// Create with the table full is answered straight from idle; join reads the target's status.
// Yield walks the next links past the skipped ring slots, and finish unlinks the current slot
// and then runs the same walk; the next-link walk sets how long a yield takes.
// One request at a time; busy is high while a request is in progress; results cannot stall.
// Reset: synchronous; afterwards a clearing pass writes all SLOT_COUNT entries,
// one per cycle, with busy high. Results are strobed one cycle on o_done.
module thread_slot_round_robin_scheduler
    import tsrr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_target_slot,
    input  logic [63:0] i_exit_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_id,
    output logic [63:0] o_joined_value,
    output logic [7:0]  o_running_slot
);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] S_ONE  = IW'(1);
    localparam logic [IW-1:0] S_ZERO = '0;
    localparam logic [IW-1:0] S_LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_CR_RD0, ST_CR_RD1, ST_CR_WR0, ST_CR_WR1,
        ST_FIN_RD, ST_FIN_WR, ST_Y_RD0, ST_Y_RD1, ST_Y_EVAL, ST_Y_SW, ST_J_EV
    } t_state;

    t_state         r_state;
    logic [IW-1:0]  r_init;
    logic [IW-1:0]  r_cur;
    logic [IW-1:0]  r_prev;
    logic [IW-1:0]  r_free;
    logic [IW-1:0]  r_a;
    logic [IW-1:0]  r_b;
    logic [IW-1:0]  r_i;
    logic [IW-1:0]  r_n;
    logic [IW-1:0]  r_tgt;
    logic [63:0]    r_val;

    logic           s_we, n_we, p_we, v_we;
    logic [IW-1:0]  s_waddr, n_waddr, p_waddr, v_waddr;
    logic [IW-1:0]  s_raddr, n_raddr, p_raddr, v_raddr;
    logic [1:0]     s_wdata, s_rdata;
    logic [IW-1:0]  n_wdata, n_rdata, p_wdata, p_rdata;
    logic [63:0]    v_rdata;

    logic [16:0]    w_tgt_wide;
    logic           w_tgt_ok;
    logic [IW-1:0]  w_tgt;
    logic           w_hit;

    assign w_tgt_wide = 17'(i_target_slot);
    assign w_tgt_ok   = w_tgt_wide < 17'(SLOT_COUNT);
    assign w_tgt      = w_tgt_wide[IW-1:0];
    assign w_hit      = (r_i != S_ZERO) && (s_rdata == SL_RUN);
    assign busy       = (r_state != ST_IDLE);

    function automatic logic [7:0] to8(input logic [IW-1:0] v);
        logic [16:0] w;
        w = 17'(v);
        return w[7:0];
    endfunction

    tsrr_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_status (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    tsrr_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_next (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(n_rdata)
    );
    tsrr_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_prev (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    tsrr_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_value (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(r_val),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    always_comb begin
        s_we = 1'b0; s_waddr = S_ZERO; s_wdata = SL_FREE; s_raddr = S_ZERO;
        n_we = 1'b0; n_waddr = S_ZERO; n_wdata = S_ZERO;  n_raddr = S_ZERO;
        p_we = 1'b0; p_waddr = S_ZERO; p_wdata = S_ZERO;  p_raddr = S_ZERO;
        v_we = 1'b0; v_waddr = S_ZERO; v_raddr = S_ZERO;
        unique case (r_state)
            ST_INIT: begin
                s_we = 1'b1; s_waddr = r_init;
                s_wdata = (r_init == S_ONE) ? SL_RUN : SL_FREE;
                n_we = 1'b1; n_waddr = r_init;
                if (r_init == S_ONE) begin
                    n_wdata = S_ONE;
                end else if (r_init >= IW'(2) && r_init < S_LAST) begin
                    n_wdata = r_init + S_ONE;
                end
                p_we = 1'b1; p_waddr = r_init;
                p_wdata = (r_init == S_ONE) ? S_ONE : S_ZERO;
            end
            ST_IDLE: begin
                s_raddr = w_tgt;
                v_raddr = w_tgt;
            end
            ST_CR_RD0: n_raddr = r_free;
            ST_CR_RD1: n_raddr = S_ONE;
            ST_CR_WR0: begin
                n_we = 1'b1; n_waddr = r_free; n_wdata = n_rdata;
                p_we = 1'b1; p_waddr = r_free; p_wdata = S_ONE;
                s_we = 1'b1; s_waddr = r_free; s_wdata = SL_RUN;
            end
            ST_CR_WR1: begin
                n_we = 1'b1; n_waddr = S_ONE; n_wdata = r_free;
                p_we = 1'b1; p_waddr = r_b;   p_wdata = r_free;
            end
            ST_FIN_RD: begin
                n_raddr = r_cur;
                p_raddr = r_cur;
            end
            ST_FIN_WR: begin
                s_we = 1'b1; s_waddr = r_cur; s_wdata = SL_FIN;
                v_we = 1'b1; v_waddr = r_cur;
                p_we = 1'b1; p_waddr = n_rdata; p_wdata = p_rdata;
                n_we = 1'b1; n_waddr = p_rdata; n_wdata = n_rdata;
            end
            ST_Y_RD0: n_raddr = r_cur;
            ST_Y_RD1: begin
                s_raddr = n_rdata;
                n_raddr = n_rdata;
            end
            ST_Y_EVAL: begin
                if (w_hit) begin
                    s_raddr = r_cur;
                end else begin
                    s_raddr = n_rdata;
                    n_raddr = n_rdata;
                end
            end
            ST_Y_SW: begin
                if (s_rdata == SL_FIN) begin
                    s_we = 1'b1; s_waddr = r_prev; s_wdata = SL_WJ;
                end
            end
            ST_J_EV: begin
                if (s_rdata == SL_WJ) begin
                    s_we = 1'b1; s_waddr = r_tgt; s_wdata = SL_FREE;
                    n_we = 1'b1; n_waddr = r_tgt; n_wdata = r_free;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_init  <= S_ZERO;
            r_cur   <= S_ONE;
            r_prev  <= S_ONE;
            r_free  <= IW'(2);
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_INIT: begin
                    r_init <= r_init + S_ONE;
                    if (r_init == S_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_val <= i_exit_value;
                        r_tgt <= w_tgt;
                        unique case (i_mode)
                            MODE_CREATE: begin
                                if (r_free == S_ZERO) begin
                                    o_done         <= 1'b1;
                                    o_status       <= STS_FULL;
                                    o_slot_id      <= 8'd0;
                                    o_joined_value <= 64'd0;
                                    o_running_slot <= to8(r_cur);
                                end else begin
                                    r_state <= ST_CR_RD0;
                                end
                            end
                            MODE_FINISH: r_state <= ST_FIN_RD;
                            MODE_YIELD:  r_state <= ST_Y_RD0;
                            MODE_JOIN: begin
                                if (w_tgt_ok) begin
                                    r_state <= ST_J_EV;
                                end else begin
                                    o_done         <= 1'b1;
                                    o_status       <= STS_NOT_READY;
                                    o_slot_id      <= i_target_slot;
                                    o_joined_value <= 64'd0;
                                    o_running_slot <= to8(r_cur);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CR_RD0: r_state <= ST_CR_RD1;
                ST_CR_RD1: begin
                    r_a     <= n_rdata;
                    r_state <= ST_CR_WR0;
                end
                ST_CR_WR0: begin
                    r_b     <= n_rdata;
                    r_state <= ST_CR_WR1;
                end
                ST_CR_WR1: begin
                    r_free         <= r_a;
                    o_done         <= 1'b1;
                    o_status       <= STS_OK;
                    o_slot_id      <= to8(r_free);
                    o_joined_value <= 64'd0;
                    o_running_slot <= to8(r_cur);
                    r_state        <= ST_IDLE;
                end
                ST_FIN_RD: r_state <= ST_FIN_WR;
                ST_FIN_WR: r_state <= ST_Y_RD0;
                ST_Y_RD0:  r_state <= ST_Y_RD1;
                ST_Y_RD1: begin
                    r_i     <= n_rdata;
                    r_n     <= S_ZERO;
                    r_state <= ST_Y_EVAL;
                end
                ST_Y_EVAL: begin
                    if (w_hit && r_i != r_cur) begin
                        r_prev  <= r_cur;
                        r_cur   <= r_i;
                        r_state <= ST_Y_SW;
                    end else if (w_hit || r_n == S_LAST) begin
                        o_done         <= 1'b1;
                        o_status       <= w_hit ? STS_OK : STS_NONE;
                        o_slot_id      <= to8(r_cur);
                        o_joined_value <= 64'd0;
                        o_running_slot <= to8(r_cur);
                        r_state        <= ST_IDLE;
                    end else begin
                        r_i <= n_rdata;
                        r_n <= r_n + S_ONE;
                    end
                end
                ST_Y_SW: begin
                    o_done         <= 1'b1;
                    o_status       <= STS_OK;
                    o_slot_id      <= to8(r_cur);
                    o_joined_value <= 64'd0;
                    o_running_slot <= to8(r_cur);
                    r_state        <= ST_IDLE;
                end
                ST_J_EV: begin
                    o_done         <= 1'b1;
                    o_slot_id      <= to8(r_tgt);
                    o_running_slot <= to8(r_cur);
                    if (s_rdata == SL_WJ) begin
                        r_free         <= r_tgt;
                        o_status       <= STS_OK;
                        o_joined_value <= v_rdata;
                    end else begin
                        o_status       <= STS_NOT_READY;
                        o_joined_value <= 64'd0;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !o_done && !(i_mode == MODE_JOIN && !w_tgt_ok)
         && !(i_mode == MODE_CREATE && r_free == S_ZERO)) |=> busy)
        else $error("accepted request did not raise busy");
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STS_FULL) |-> (o_slot_id == 8'd0))
        else $error("table full result carries a slot id");
    a_notready_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STS_NOT_READY) |-> (o_joined_value == 64'd0))
        else $error("join not ready carries a value");
    a_cur_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_cur != S_ZERO))
        else $error("current slot became zero");
endmodule

@@ tb/tb_thread_slot_round_robin_scheduler.sv @@
// Testbench for the thread-slot round-robin scheduler: directed and random requests with a scoreboard.
`timescale 1ns / 100ps

module tb_thread_slot_round_robin_scheduler;
    import tsrr_pkg::*;

    localparam int NSLOT     = 256;
    localparam int LIMIT     = 2000000;
    localparam int TAIL_WAIT = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_id;
        logic [63:0] joined_value;
        logic [7:0]  running_slot;
    } sched_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = MODE_CREATE;
    logic [7:0]  i_target_slot = '0;
    logic [63:0] i_exit_value = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [7:0]  o_slot_id;
    logic [63:0] o_joined_value;
    logic [7:0]  o_running_slot;

    sched_result_t sched_expected[$];
    int          errors = 0;
    int          cycles = 0;
    bit          gaps_on = 1'b1;

    logic [7:0]  cur_slot, prev_slot, free_hd;
    logic [1:0]  slot_st[NSLOT];
    logic [7:0]  nxt[NSLOT];
    logic [7:0]  prv[NSLOT];
    logic [63:0] saved[NSLOT];

    thread_slot_round_robin_scheduler dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [1:0] sched_walk();
        logic [7:0] i;
        i = nxt[cur_slot];
        for (int n = 0; n < NSLOT; n++) begin
            if (i != 0 && slot_st[i] == SL_RUN) begin
                if (i != cur_slot) begin
                    prev_slot = cur_slot;
                    cur_slot = i;
                    if (slot_st[prev_slot] == SL_FIN) slot_st[prev_slot] = SL_WJ;
                end
                return STS_OK;
            end
            i = nxt[i];
        end
        return STS_NONE;
    endfunction

    task automatic sched_reset_model();
        for (int i = 0; i < NSLOT; i++) begin
            slot_st[i] = SL_FREE;
            nxt[i] = (i >= 2 && i < NSLOT - 1) ? 8'(i + 1) : 8'd0;
            prv[i] = '0;
            saved[i] = '0;
        end
        nxt[1] = 8'd1;
        prv[1] = 8'd1;
        slot_st[1] = SL_RUN;
        cur_slot = 8'd1;
        prev_slot = 8'd1;
        free_hd = 8'd2;
    endtask

    task automatic sched_predict(logic [1:0] mode, logic [7:0] tgt, logic [63:0] val);
        sched_result_t r;
        logic [7:0] f, succ, c, nx, pv;
        r = '0;
        case (mode)
            MODE_CREATE: begin
                f = free_hd;
                if (f == 0) begin
                    r.status = STS_FULL;
                end else begin
                    succ = nxt[1];
                    free_hd = nxt[f];
                    nxt[f] = succ;
                    prv[f] = 8'd1;
                    prv[succ] = f;
                    nxt[1] = f;
                    slot_st[f] = SL_RUN;
                    r.slot_id = f;
                end
            end
            MODE_FINISH: begin
                c = cur_slot;
                nx = nxt[c];
                pv = prv[c];
                slot_st[c] = SL_FIN;
                saved[c] = val;
                prv[nx] = pv;
                nxt[pv] = nx;
                r.status = sched_walk();
                r.slot_id = cur_slot;
            end
            MODE_YIELD: begin
                r.status = sched_walk();
                r.slot_id = cur_slot;
            end
            default: begin
                r.slot_id = tgt;
                if (slot_st[tgt] == SL_WJ) begin
                    r.joined_value = saved[tgt];
                    slot_st[tgt] = SL_FREE;
                    nxt[tgt] = free_hd;
                    free_hd = tgt;
                end else begin
                    r.status = STS_NOT_READY;
                end
            end
        endcase
        r.running_slot = cur_slot;
        sched_expected.push_back(r);
    endtask

    always @(posedge i_clk) begin
        sched_result_t e;
        if (i_rst_n && o_done) begin
            if (sched_expected.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = sched_expected.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_slot_id !== e.slot_id) begin
                    $error("slot_id exp %0d got %0d", e.slot_id, o_slot_id);
                    errors++;
                end
                if (o_joined_value !== e.joined_value) begin
                    $error("joined_value exp %h got %h", e.joined_value, o_joined_value);
                    errors++;
                end
                if (o_running_slot !== e.running_slot) begin
                    $error("running_slot exp %0d got %0d", e.running_slot, o_running_slot);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(logic [1:0] mode, logic [7:0] tgt, logic [63:0] val);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_mode = mode;
        i_target_slot = tgt;
        i_exit_value = val;
        do @(posedge i_clk); while (busy);
        sched_predict(mode, tgt, val);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (sched_expected.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_join_target();
        int s;
        s = $urandom_range(0, NSLOT - 1);
        for (int n = 0; n < NSLOT; n++) begin
            if (slot_st[(s + n) % NSLOT] == SL_WJ) return 8'((s + n) % NSLOT);
        end
        return prev_slot;
    endfunction

    task automatic test_directed();
        send_req(MODE_YIELD, 8'hFF, '0);
        send_req(MODE_JOIN, 8'd0, '0);
        send_req(MODE_JOIN, 8'd255, '0);
        send_req(MODE_FINISH, 8'd0, '1);
        send_req(MODE_YIELD, 8'd0, '0);
        send_req(MODE_JOIN, 8'd1, '0);
        send_req(MODE_CREATE, 8'hAA, '1);
        send_req(MODE_CREATE, 8'h55, '0);
        send_req(MODE_YIELD, 8'd0, '0);
        send_req(MODE_FINISH, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(MODE_JOIN, 8'd3, '0);
        send_req(MODE_YIELD, 8'd0, '0);
        send_req(MODE_JOIN, prev_slot, '0);
        send_req(MODE_JOIN, 8'd2, '0);
        send_req(MODE_FINISH, 8'd0, '0);
        send_req(MODE_FINISH, 8'd0, 64'h8000_0000_0000_0001);
        send_req(MODE_YIELD, 8'd0, '0);
        send_req(MODE_JOIN, pick_join_target(), '0);
        send_req(MODE_CREATE, 8'd0, '0);
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < 260; i++) send_req(MODE_CREATE, 8'($urandom), {$urandom, $urandom});
    endtask

    task automatic test_random(int count, int create_w);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < create_w)
                send_req(MODE_CREATE, 8'($urandom), {$urandom, $urandom});
            else if (r < create_w + 25)
                send_req(MODE_FINISH, 8'($urandom), {$urandom, $urandom});
            else if (r < create_w + 50)
                send_req(MODE_YIELD, 8'($urandom), {$urandom, $urandom});
            else if (r < create_w + 60)
                send_req(MODE_JOIN, 8'($urandom), {$urandom, $urandom});
            else
                send_req(MODE_JOIN, pick_join_target(), {$urandom, $urandom});
        end
    endtask

    initial begin
        int wait_cycles;
        sched_reset_model();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(250, 30);
        drain();
        test_fill_table();
        test_random(250, 10);
        drain();
        test_random(150, 25);
        gaps_on = 1'b0;
        test_random(150, 20);
        wait_cycles = 0;
        while (sched_expected.size() != 0 && wait_cycles < 10000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (errors == 0 && sched_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tsrr_pkg.sv
rtl/tsrr_ram.sv
rtl/thread_slot_round_robin_scheduler.sv
tb/tb_thread_slot_round_robin_scheduler.sv
